FILE: hdl/pdol_pkg.sv
// Package: shared types, constants and command/status structs for the oscillator loop.
`default_nettype none
package pdol_pkg;

  localparam int unsigned PulsesPerGate = 2;
  localparam int unsigned LockRuns      = 4;

  localparam logic [2:0] RegExpected = 3'd0;
  localparam logic [2:0] RegMinGap   = 3'd1;
  localparam logic [2:0] RegCoarse   = 3'd2;
  localparam logic [2:0] RegFine     = 3'd3;
  localparam logic [2:0] RegLockScl  = 3'd4;
  localparam logic [2:0] RegKi       = 3'd5;
  localparam logic [2:0] RegKp       = 3'd6;
  localparam logic [2:0] RegKd       = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_INTEG,
    ST_MUL_I,
    ST_MUL_P,
    ST_MUL_D,
    ST_CTRL,
    ST_DIV,
    ST_FRAC,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take_edge;
    logic do_integ;
    logic mul_i;
    logic mul_p;
    logic mul_d;
    logic do_ctrl;
    logic div_start;
    logic div_step;
    logic do_frac;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic window_done;
    logic primed;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

FILE: hdl/pdol_ctrl.sv
// Controller: sequences gate processing, PID multiplies, division and output.
`default_nettype none
module pdol_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          out_busy_i,
  input  wire pdol_pkg::sts_t sts_i,
  output pdol_pkg::cmd_t     cmd_o
);
  import pdol_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take_edge = 1'b1;
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (sts_i.window_done && sts_i.primed) state_d = ST_INTEG;
        else state_d = ST_IDLE;
      end
      ST_INTEG: begin
        cmd_o.do_integ = 1'b1;
        state_d = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd_o.mul_i = 1'b1;
        state_d = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd_o.mul_p = 1'b1;
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd_o.mul_d = 1'b1;
        state_d = ST_CTRL;
      end
      ST_CTRL: begin
        cmd_o.do_ctrl   = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_FRAC;
      end
      ST_FRAC: begin
        cmd_o.do_frac = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/pdol_dp.sv
// Datapath: gate/window accumulation, PID, duty clamp, frequency division and lock.
`default_nettype none
module pdol_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_addr_i,
  input  wire logic [31:0]    cfg_data_i,
  input  wire logic [31:0]    edge_time_i,
  input  wire pdol_pkg::cmd_t cmd_i,
  output pdol_pkg::sts_t      sts_o,
  output logic signed [31:0]  error_ticks_o,
  output logic signed [31:0]  control_delta_o,
  output logic [15:0]         duty_o,
  output logic                locked_o,
  output logic signed [31:0]  freq_offset_hz_o,
  output logic [19:0]         freq_frac_uhz_o
);
  import pdol_pkg::*;

  localparam logic signed [63:0] S32Max = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32Min = -64'sh0000_0000_8000_0000;

  // configuration
  logic [31:0] exp_q, gap_min_q;
  logic [9:0]  coarse_q, fine_q;
  logic [19:0] lscale_q;
  logic signed [15:0] ki_q, kp_q, kd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q     <= 32'd9999892;
      gap_min_q <= 32'd5000;
      coarse_q  <= 10'd2;
      fine_q    <= 10'd10;
      lscale_q  <= 20'd1000;
      ki_q      <= 16'sd8;
      kp_q      <= 16'sd256;
      kd_q      <= 16'sd16;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegExpected: exp_q     <= cfg_data_i;
        RegMinGap:   gap_min_q <= cfg_data_i;
        RegCoarse:   coarse_q  <= cfg_data_i[9:0];
        RegFine:     fine_q    <= cfg_data_i[9:0];
        RegLockScl:  lscale_q  <= cfg_data_i[19:0];
        RegKi:       ki_q      <= cfg_data_i[15:0];
        RegKp:       kp_q      <= cfg_data_i[15:0];
        RegKd:       kd_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // loop state
  logic [31:0] last_q, wsum_q;
  logic [9:0]  pcnt_q, wcnt_q;
  logic signed [31:0] integ_q, prev_q, err_q;
  logic [15:0] duty_q;
  logic [7:0]  run_q;
  logic        locked_q, primed_q, done_q;
  logic        primed_prev_q;
  logic [9:0]  win_q;

  logic [31:0] gap;
  logic [9:0]  pcnt_inc, wcnt_inc, win_sel;
  logic [31:0] wsum_new;
  assign gap      = edge_time_i - last_q;
  assign pcnt_inc = pcnt_q + 10'd1;
  assign wcnt_inc = wcnt_q + 10'd1;
  assign wsum_new = wsum_q + (gap - exp_q);
  always_comb begin
    win_sel = locked_q ? fine_q : coarse_q;
    if (win_sel == 10'd0) win_sel = 10'd1;
  end

  // PID registers
  logic signed [63:0] acc_q, prod_q;
  logic signed [31:0] ctrl_q;
  logic signed [63:0] integ_sum, neg_acc;
  logic signed [32:0] derr;
  assign integ_sum = 64'(integ_q) + 64'(err_q);
  assign derr      = 33'(err_q) - 33'(prev_q);
  assign neg_acc   = -(acc_q + prod_q);

  // divider (restoring, magnitude), floor fix after
  logic [31:0] dq_q, drem_q;
  logic [31:0] mag;
  logic [5:0]  dcnt_q;
  logic [32:0] trial;
  assign mag   = err_q[31] ? 32'(-err_q) : err_q;
  assign trial = {drem_q, dq_q[31]} - {23'd0, win_q};

  // second restoring divider, same steps: micro-hertz per tick, 1000000 / window
  logic [31:0] uq_q, urem_q;
  logic [32:0] utrial;
  assign utrial = {urem_q, uq_q[31]} - {23'd0, win_q};

  logic signed [33:0] hz_s;
  logic [31:0] r_fix;
  logic [19:0] upw;
  always_comb begin
    if (err_q[31] && drem_q != 32'd0) begin
      hz_s  = -34'(dq_q) - 34'sd1;
      r_fix = 32'(win_q) - drem_q;
    end else if (err_q[31]) begin
      hz_s  = -34'(dq_q);
      r_fix = '0;
    end else begin
      hz_s  = 34'(dq_q);
      r_fix = drem_q;
    end
  end
  assign upw = uq_q[19:0];

  // |err| > floor(scale * window / 1000)  <=>  |err| * 1000 > scale * window
  logic [41:0] mag_k, lim;
  assign mag_k = 42'(mag) * 42'd1000;
  assign lim   = 42'(lscale_q) * 42'(win_q);

  logic signed [32:0] duty_ext;
  assign duty_ext = 33'(ctrl_q) + 33'($signed({1'b0, duty_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0; wsum_q <= '0; pcnt_q <= '0; wcnt_q <= '0;
      integ_q <= '0; prev_q <= '0; duty_q <= 16'd32767; run_q <= '0;
      locked_q <= 1'b0; primed_q <= 1'b0; done_q <= 1'b0;
      err_q <= '0; win_q <= 10'd1; dcnt_q <= '0;
      acc_q <= '0; prod_q <= '0; ctrl_q <= '0;
      dq_q <= '0; drem_q <= '0; uq_q <= '0; urem_q <= '0;
      freq_offset_hz_o <= '0; freq_frac_uhz_o <= '0;
    end else begin
      if (cmd_i.take_edge) begin
        done_q <= 1'b0;
        if (gap > gap_min_q) begin
          if (pcnt_inc >= 10'(PulsesPerGate)) begin
            pcnt_q <= '0;
            last_q <= edge_time_i;
            win_q  <= win_sel;
            if (wcnt_inc >= win_sel) begin
              err_q    <= wsum_new;
              wsum_q   <= '0;
              wcnt_q   <= '0;
              done_q   <= 1'b1;
              primed_q <= 1'b1;
            end else begin
              wsum_q <= wsum_new;
              wcnt_q <= wcnt_inc;
            end
          end else begin
            pcnt_q <= pcnt_inc;
          end
        end
      end
      if (cmd_i.do_integ) begin
        integ_q <= (integ_sum > S32Max) ? 32'sh7FFF_FFFF :
                   (integ_sum < S32Min) ? 32'sh8000_0000 : integ_sum[31:0];
      end
      if (cmd_i.mul_i) begin
        acc_q  <= '0;
        prod_q <= 64'(integ_q) * 64'(ki_q);
      end
      if (cmd_i.mul_p) begin
        acc_q  <= acc_q + prod_q;
        prod_q <= 64'(err_q) * 64'(kp_q);
      end
      if (cmd_i.mul_d) begin
        acc_q  <= acc_q + prod_q;
        prod_q <= 64'(derr) * 64'(kd_q);
        prev_q <= err_q;
      end
      if (cmd_i.do_ctrl) begin
        ctrl_q <= (neg_acc > S32Max) ? 32'sh7FFF_FFFF :
                  (neg_acc < S32Min) ? 32'sh8000_0000 : neg_acc[31:0];
      end
      if (cmd_i.div_start) begin
        dq_q   <= mag;
        drem_q <= '0;
        uq_q   <= 32'd1000000;
        urem_q <= '0;
        dcnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 6'd1;
        if (!trial[32]) begin
          drem_q <= trial[31:0];
          dq_q   <= {dq_q[30:0], 1'b1};
        end else begin
          drem_q <= {drem_q[30:0], dq_q[31]};
          dq_q   <= {dq_q[30:0], 1'b0};
        end
        if (!utrial[32]) begin
          urem_q <= utrial[31:0];
          uq_q   <= {uq_q[30:0], 1'b1};
        end else begin
          urem_q <= {urem_q[30:0], uq_q[31]};
          uq_q   <= {uq_q[30:0], 1'b0};
        end
      end
      if (cmd_i.do_frac) begin
        if (ctrl_q != 32'sd0) begin
          duty_q <= (duty_ext < 33'sd1) ? 16'd1 :
                    (duty_ext > 33'sd65535) ? 16'hFFFF : duty_ext[15:0];
        end
        freq_offset_hz_o <= hz_s[31:0];
        freq_frac_uhz_o  <= 20'(r_fix * 32'(upw));
        if (mag_k > lim) begin
          run_q <= '0;
          locked_q <= 1'b0;
        end else begin
          if (run_q <= 8'(LockRuns)) run_q <= run_q + 8'd1;
          locked_q <= (run_q + 8'd1) > 8'(LockRuns);
        end
      end
    end
  end

  // primed state as it was before the edge just taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) primed_prev_q <= 1'b0;
    else if (cmd_i.take_edge) primed_prev_q <= primed_q;
  end

  assign sts_o.window_done = done_q;
  assign sts_o.primed      = primed_prev_q;
  assign sts_o.div_last    = (dcnt_q == 6'd31);

  assign error_ticks_o   = err_q;
  assign control_delta_o = ctrl_q;
  assign duty_o          = duty_q;
  assign locked_o        = locked_q;

endmodule
`default_nettype wire

FILE: hdl/pps_disciplined_oscillator_loop.sv
// Reference-pulse disciplined oscillator loop, top level with output register.
// An edge with no result returns to idle; an accepted edge runs gate check, integrate,
//   PID multiplies, control, divider, fixup and output load, in that order.
// A new edge is taken only once the previous one is through, output stall included.
// Reset: asynchronous active low; registers to defaults, duty 32767, first window dropped;
//   the output data registers are not reset.
`default_nettype none
module pps_disciplined_oscillator_loop (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_addr_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [31:0]        edge_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      error_ticks_o,
  output logic signed [31:0]      control_delta_o,
  output logic [15:0]             duty_o,
  output logic                    locked_o,
  output logic signed [31:0]      freq_offset_hz_o,
  output logic [19:0]             freq_frac_uhz_o
);
  import pdol_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [31:0] err_w, ctl_w, hz_w;
  logic [15:0] duty_w;
  logic lock_w;
  logic [19:0] frac_w;
  logic out_valid_q;

  pdol_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i(out_valid_q & out_stall_i),
    .sts_i(sts), .cmd_o(cmd)
  );

  pdol_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i, .edge_time_i,
    .cmd_i(cmd), .sts_o(sts),
    .error_ticks_o(err_w), .control_delta_o(ctl_w), .duty_o(duty_w),
    .locked_o(lock_w), .freq_offset_hz_o(hz_w), .freq_frac_uhz_o(frac_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      error_ticks_o    <= err_w;
      control_delta_o  <= ctl_w;
      duty_o           <= duty_w;
      locked_o         <= lock_w;
      freq_offset_hz_o <= hz_w;
      freq_frac_uhz_o  <= frac_w;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
